// ----- hw/rtl/i2cbs_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbs_pkg
// shared types and codes for the i2c master bit sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbs_pkg;

	localparam int BITS_PER_BYTE = 8;

	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_STOP  = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_WAIT  = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;
	localparam logic [2:0] CMD_IDLE  = 3'd7;

	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [2:0] command;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} out_item_t;

	typedef struct packed {
		logic [2:0]               active_command;
		logic [1:0]               step_index;
		logic [3:0]               bit_count;
		logic [BITS_PER_BYTE-1:0] shift_reg;
		logic                     ack_choice;
		logic                     scl;
		logic                     sda;
		logic                     drv;
		logic                     ack_fail;
		logic [BITS_PER_BYTE-1:0] rx_hold;
	} seq_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/i2c_master_bit_sequencer_core.sv -----
// flow: an accepted item sits in the input register and its result is loaded into
// the output register once the output register is empty or not stalled
// throughput: one item per cycle unless the output stalls, set by the single next-state pass
// reset: lines come up clock high, data high, driving; sequencer idle;
// both pipeline registers empty
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// open-drain i2c master line sequencer, one delay interval per tick item
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer_core import i2cbs_pkg::*; (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire            out_stall,
	output out_item_t      out_item
);

	logic       valid_s1;
	in_item_t   item_s1;
	seq_state_t st_q;
	seq_state_t st_nxt;
	out_item_t  res_nxt;
	logic       res_load;
	logic       adv;

	i2cbs_step u_step (
		.item (item_s1),
		.cur  (st_q),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	assign res_load = ~out_valid | ~out_stall;
	assign adv      = valid_s1 & res_load;
	assign in_stall = valid_s1 & ~res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{active_command: CMD_IDLE, step_index: 2'd0, bit_count: 4'd0,
				shift_reg: '0, ack_choice: 1'b0, scl: 1'b1, sda: 1'b1, drv: 1'b1,
				ack_fail: 1'b0, rx_hold: '0};
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_load) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item <= res_nxt;
		end
	end

	// idle sequencer keeps its step at zero
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.active_command == CMD_IDLE) |-> (st_q.step_index == 2'd0))
		else $error("step index nonzero while idle");

	// bit counter never passes a full byte
	a_bit_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bit_count <= 4'(BITS_PER_BYTE))
		else $error("bit count out of range");

	// a done item leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_nxt.done_res) |=> (st_q.active_command == CMD_IDLE))
		else $error("done without returning to idle");

	// input side only stalls behind a held item
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("stall without a waiting result");

endmodule

`default_nettype wire

// ----- hw/rtl/i2cbs_step.sv -----
// ----------------------------------------------------------------------------
// i2cbs_step
// next-state and result logic for one command or tick item
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_step import i2cbs_pkg::*; (
	input  wire in_item_t   item,
	input  wire seq_state_t cur,
	output seq_state_t      nxt,
	output out_item_t       res
);

	logic       done;
	logic [3:0] bc_inc;
	logic [7:0] rx_shift;

	assign bc_inc   = cur.bit_count + 4'd1;
	assign rx_shift = {cur.shift_reg[6:0], item.sda_in};

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if (item.kind == KIND_CMD) begin
			if (cur.active_command == CMD_IDLE) begin
				nxt.step_index = 2'd0;
				case (item.command)
					CMD_START: begin
						nxt.scl = 1'b1;
						nxt.sda = 1'b1;
						nxt.drv = 1'b1;
						nxt.active_command = item.command;
					end
					CMD_STOP: begin
						nxt.scl = 1'b0;
						nxt.sda = 1'b0;
						nxt.drv = 1'b1;
						nxt.active_command = item.command;
					end
					CMD_WRITE: begin
						nxt.bit_count = 4'd0;
						nxt.scl = 1'b0;
						nxt.drv = 1'b1;
						nxt.sda = item.tx_byte[7];
						nxt.shift_reg = {item.tx_byte[6:0], 1'b0};
						nxt.active_command = item.command;
					end
					CMD_WAIT: begin
						nxt.scl = 1'b0;
						nxt.drv = 1'b0;
						nxt.active_command = item.command;
					end
					CMD_READ: begin
						nxt.ack_choice = item.send_ack;
						nxt.shift_reg = '0;
						nxt.bit_count = 4'd0;
						nxt.scl = 1'b0;
						nxt.drv = 1'b0;
						nxt.active_command = item.command;
					end
					default: begin
					end
				endcase
			end
		end else begin
			case (cur.active_command)
				CMD_START: begin
					if (cur.step_index == 2'd0) begin
						nxt.sda = 1'b0;
						nxt.step_index = 2'd1;
					end else begin
						nxt.scl = 1'b0;
						done = 1'b1;
					end
				end
				CMD_STOP: begin
					if (cur.step_index == 2'd0) begin
						nxt.scl = 1'b1;
						nxt.step_index = 2'd1;
					end else if (cur.step_index == 2'd1) begin
						nxt.sda = 1'b1;
						nxt.step_index = 2'd2;
					end else begin
						done = 1'b1;
					end
				end
				CMD_WRITE: begin
					if (cur.step_index == 2'd0) begin
						nxt.scl = 1'b1;
						nxt.step_index = 2'd1;
					end else if (cur.step_index == 2'd1) begin
						nxt.scl = 1'b0;
						nxt.step_index = 2'd2;
					end else begin
						nxt.bit_count = bc_inc;
						if (bc_inc >= 4'(BITS_PER_BYTE)) begin
							done = 1'b1;
						end else begin
							nxt.sda = cur.shift_reg[7];
							nxt.shift_reg = {cur.shift_reg[6:0], 1'b0};
							nxt.step_index = 2'd0;
						end
					end
				end
				CMD_WAIT: begin
					if (cur.step_index == 2'd0) begin
						nxt.scl = 1'b1;
						nxt.step_index = 2'd1;
					end else if (cur.step_index == 2'd1) begin
						nxt.drv = 1'b1;
						nxt.scl = 1'b0;
						nxt.ack_fail = item.sda_in;
						if (item.sda_in) begin
							done = 1'b1;
						end else begin
							nxt.step_index = 2'd2;
						end
					end else begin
						done = 1'b1;
					end
				end
				CMD_READ: begin
					if (cur.step_index == 2'd0) begin
						nxt.scl = 1'b1;
						nxt.step_index = 2'd1;
					end else if (cur.step_index == 2'd1) begin
						nxt.shift_reg = rx_shift;
						nxt.bit_count = bc_inc;
						nxt.scl = 1'b0;
						if (bc_inc >= 4'(BITS_PER_BYTE)) begin
							nxt.rx_hold = rx_shift;
							nxt.drv = 1'b1;
							nxt.sda = ~cur.ack_choice;
							nxt.step_index = 2'd2;
						end else begin
							nxt.step_index = 2'd0;
						end
					end else if (cur.step_index == 2'd2) begin
						nxt.scl = 1'b1;
						nxt.step_index = 2'd3;
					end else begin
						nxt.scl = 1'b0;
						done = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (done) begin
				nxt.active_command = CMD_IDLE;
				nxt.step_index = 2'd0;
			end
		end
	end

	always_comb begin
		res.scl_level  = nxt.scl;
		res.sda_level  = nxt.sda;
		res.sda_drive  = nxt.drv;
		res.busy_res   = (nxt.active_command != CMD_IDLE);
		res.done_res   = done;
		res.rx_byte    = nxt.rx_hold;
		res.ack_failed = nxt.ack_fail;
	end

endmodule

`default_nettype wire
